// ===== rtl/idf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// idf_pkg: shared types and constants of the integer decimal formatter
// Holds the ASCII codes, digit limits and the stage-to-stage item record.
// ----------------------------------------------------------------------------
package idf_pkg;

  localparam int unsigned NumDigits = 20;   // digits of a 64-bit magnitude
  localparam int unsigned BcdW      = 4 * NumDigits;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSpace = 8'h20;

  // Item record between the conversion pipeline and the emitter
  typedef struct packed {
    logic [BcdW-1:0] bcd;        // digits, least significant nibble first
    logic [6:0]      ndig;       // digits to print
    logic [7:0]      sign_ch;    // sign character
    logic            has_sign;
    logic            left;
    logic            zero_fill;
    logic [6:0]      width;
  } idf_item_t;

endpackage
`default_nettype wire

// ===== rtl/idf_bcd_pipe.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// idf_bcd_pipe: binary to decimal pipeline
// Double-dabble over 64 bits, eight bit shifts per stage, with a front stage
// that takes the magnitude and the sign and a back stage that sizes the text.
// ----------------------------------------------------------------------------
module idf_bcd_pipe (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output logic                       stall_o,
  input  wire logic [63:0]           value_i,
  input  wire logic                  is_unsigned_i,
  input  wire logic                  left_justify_i,
  input  wire logic                  zero_pad_i,
  input  wire logic                  force_plus_i,
  input  wire logic                  space_sign_i,
  input  wire logic                  has_precision_i,
  input  wire logic [5:0]            min_digits_i,
  input  wire logic [6:0]            field_width_i,
  output logic                       valid_o,
  input  wire logic                  stall_i,
  output idf_pkg::idf_item_t         item_o
);
  import idf_pkg::*;

  localparam int unsigned NStg = 8;   // shift stages of 8 bits each

  typedef struct packed {
    logic [BcdW-1:0] bcd;
    logic [63:0]     bin;
    logic [7:0]      sign_ch;
    logic            has_sign;
    logic            left;
    logic            zero_fill;
    logic            dot;
    logic [5:0]      prec;
    logic [6:0]      width;
  } work_t;

  function automatic logic [BcdW-1:0] dabble(input logic [BcdW-1:0] b);
    logic [BcdW-1:0] r;
    r = b;
    for (int k = 0; k < NumDigits; k++) begin
      if (r[4*k +: 4] > 4'd4) r[4*k +: 4] = r[4*k +: 4] + 4'd3;
    end
    return r;
  endfunction

  // stages: 0 front, 1..NStg shift, NStg+1 sizing
  work_t           stg_q  [NStg+1];
  logic [NStg:0]   vld_q;
  idf_item_t       out_q;
  logic            out_vld_q;
  logic            adv;

  // Advance the whole pipe together when the output is free
  assign adv     = !(out_vld_q && stall_i);
  assign stall_o = !adv;
  assign valid_o = out_vld_q;
  assign item_o  = out_q;

  // Front stage: magnitude and sign
  work_t fr_d;
  always_comb begin
    logic neg;
    neg = !is_unsigned_i && value_i[63];
    fr_d          = '0;
    fr_d.bin      = is_unsigned_i ? {32'd0, value_i[31:0]} :
                    (neg ? (64'd0 - value_i) : value_i);
    fr_d.has_sign = neg || (!is_unsigned_i && (force_plus_i || space_sign_i));
    fr_d.sign_ch  = neg ? ChMinus : (force_plus_i ? ChPlus : ChSpace);
    fr_d.left     = left_justify_i;
    fr_d.zero_fill= zero_pad_i && !left_justify_i && !has_precision_i;
    fr_d.dot      = has_precision_i;
    fr_d.prec     = min_digits_i;
    fr_d.width    = field_width_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) stg_q[0] <= fr_d;
  end

  // Shift stages: eight dabble-and-shift steps each
  for (genvar s = 1; s <= NStg; s++) begin : g_stg
    work_t nx;
    always_comb begin
      nx = stg_q[s-1];
      for (int j = 0; j < 8; j++) begin
        nx.bcd = dabble(nx.bcd);
        {nx.bcd, nx.bin} = {nx.bcd[BcdW-2:0], nx.bin, 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) stg_q[s] <= nx;
    end
  end

  // Sizing stage: natural digit count, precision, zero with zero precision
  idf_item_t it_d;
  always_comb begin
    work_t w;
    logic [6:0] nat;
    w   = stg_q[NStg];
    nat = 7'd1;
    for (int k = 1; k < NumDigits; k++) begin
      if (w.bcd[4*k +: 4] != 4'd0) nat = 7'(k + 1);
    end
    it_d.bcd       = w.bcd;
    it_d.ndig      = (nat < {1'b0, w.prec}) ? {1'b0, w.prec} : nat;
    if (w.bcd == '0 && w.dot && w.prec == 6'd0) it_d.ndig = 7'd0;
    it_d.sign_ch   = w.sign_ch;
    it_d.has_sign  = w.has_sign;
    it_d.left      = w.left;
    it_d.zero_fill = w.zero_fill;
    it_d.width     = w.width;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[NStg];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= it_d;
  end

endmodule
`default_nettype wire

// ===== rtl/integer_decimal_formatter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// integer_decimal_formatter: printf-style decimal integer text
// Path: an input beat passes the front, shift and sizing stage registers, then the emitter loads it.
// Throughput: one character beat per cycle while out_stall_i is low; an item
//   holds the emitter until its text, capped at MAX_CHARS, is out, and the whole
//   conversion pipe freezes while its output beat waits for the emitter.
// Reset: asynchronous, active low; clears all valid bits and the emitter.
// ----------------------------------------------------------------------------
module integer_decimal_formatter #(
  parameter int unsigned MAX_CHARS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] value_i,
  input  wire logic        is_unsigned_i,
  input  wire logic        left_justify_i,
  input  wire logic        zero_pad_i,
  input  wire logic        force_plus_i,
  input  wire logic        space_sign_i,
  input  wire logic        has_precision_i,
  input  wire logic [5:0]  min_digits_i,
  input  wire logic [6:0]  field_width_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       char_out_o,
  output logic             is_last_o
);
  import idf_pkg::*;

  localparam int unsigned PosW = 8;   // covers text length up to 128

  logic      it_vld;
  logic      it_stall;
  idf_item_t it;

  idf_bcd_pipe u_pipe (
    .clk_i, .rst_ni,
    .valid_i(in_valid_i), .stall_o(in_stall_o),
    .value_i, .is_unsigned_i, .left_justify_i, .zero_pad_i, .force_plus_i,
    .space_sign_i, .has_precision_i, .min_digits_i, .field_width_i,
    .valid_o(it_vld), .stall_i(it_stall), .item_o(it)
  );

  // Emitter: one character a cycle from the held item while out_stall_i is low
  idf_item_t  cur_q;
  logic       busy_q;
  logic [PosW-1:0] pos_q, n_q;
  logic [PosW-1:0] len, tot, ncap;
  logic       take;

  always_comb begin
    len  = PosW'(it.ndig) + PosW'(it.has_sign);
    tot  = (PosW'(it.width) < len) ? len : PosW'(it.width);
    ncap = (tot < PosW'(MAX_CHARS)) ? tot : PosW'(MAX_CHARS);
  end

  logic last_beat;
  assign last_beat = busy_q && !out_stall_i && (pos_q + 1'b1 == n_q);
  // Load a new item when idle or when the current one finishes
  assign take     = it_vld && (!busy_q || last_beat);
  assign it_stall = !(!busy_q || last_beat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
      n_q    <= '0;
    end else if (take) begin
      busy_q <= (ncap != '0);
      pos_q  <= '0;
      n_q    <= ncap;
    end else if (last_beat) begin
      busy_q <= 1'b0;
    end else if (busy_q && !out_stall_i) begin
      pos_q  <= pos_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) cur_q <= it;
  end

  // Character at the current position
  logic [PosW-1:0] ctot, clen, dstart, dpos;
  logic            is_dig;
  logic [PosW-1:0] didx;
  logic [4:0]      dsel;
  always_comb begin
    clen = PosW'(cur_q.ndig) + PosW'(cur_q.has_sign);
    ctot = (PosW'(cur_q.width) < clen) ? clen : PosW'(cur_q.width);
    if (cur_q.left)           dstart = PosW'(cur_q.has_sign);
    else                      dstart = ctot - PosW'(cur_q.ndig);
    dpos   = pos_q - dstart;
    is_dig = (pos_q >= dstart) && (dpos < PosW'(cur_q.ndig));
    didx   = PosW'(cur_q.ndig) - 1'b1 - dpos;
    dsel   = didx[4:0];
    char_out_o = cur_q.zero_fill ? ChZero : ChSpace;
    if (is_dig) begin
      // Digits beyond the converted ones are leading zeros
      char_out_o = (didx < PosW'(NumDigits)) ? (ChZero | {4'd0, cur_q.bcd[4*dsel +: 4]})
                                             : ChZero;
    end else if (cur_q.has_sign) begin
      if (cur_q.left || cur_q.zero_fill) begin
        if (pos_q == '0) char_out_o = cur_q.sign_ch;
      end else if (pos_q + 1'b1 == dstart) begin
        char_out_o = cur_q.sign_ch;
      end
    end
  end

  assign out_valid_o = busy_q;
  assign is_last_o   = (pos_q + 1'b1 == n_q);

  // Position stays inside the capped text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pos_q < n_q && n_q <= PosW'(MAX_CHARS)))
    else $error("position outside text");
  // A stalled character holds its position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && out_stall_i) |=> (busy_q && $stable(pos_q)))
    else $error("stalled beat moved");
  // No item loaded while one is still mid-text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !last_beat) |-> it_stall)
    else $error("emitter overrun");

endmodule
`default_nettype wire
